// ----- hdl/sllc_pkg.sv -----
// Package for the linked list with cursor: operation codes, status codes
// and the write-enable group passed to the node memory.
// Depends on nothing; every other file imports it.
`default_nettype none

package sllc_pkg;

  typedef enum logic [3:0] {
    OP_CLEAR       = 4'd0,
    OP_INS_HEAD    = 4'd1,
    OP_CUR_TO_HEAD = 4'd2,
    OP_READ_HEAD   = 4'd3,
    OP_DEL_HEAD    = 4'd4,
    OP_DEL_AFTER   = 4'd5,
    OP_INS_AFTER   = 4'd6,
    OP_READ_CUR    = 4'd7,
    OP_WRITE_CUR   = 4'd8,
    OP_ADVANCE     = 4'd9
  } op_e;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_EMPTY     = 2'd2;
  localparam logic [1:0] STAT_NO_CURSOR = 2'd3;

  typedef struct packed {
    logic next_we;
    logic value_we;
  } mem_wr_t;

endpackage

`default_nettype wire

// ----- hdl/sllc_node_mem.sv -----
// Node pool storage: the link array and the value array, each a synchronous
// memory with one write port and one registered read port.
// Depends on sllc_pkg for the write-enable group.
`default_nettype none

module sllc_node_mem
  import sllc_pkg::*;
#(
  parameter int NODES      = 256,
  parameter int PTR_BITS   = 9,
  parameter int VALUE_BITS = 32,
  localparam int IdxBits   = $clog2(NODES)
) (
  input  wire logic                         clk_i,
  input  wire mem_wr_t                      wr_i,
  input  wire logic [IdxBits-1:0]           next_raddr_i,
  output logic      [PTR_BITS-1:0]          next_rdata_o,
  input  wire logic [IdxBits-1:0]           next_waddr_i,
  input  wire logic [PTR_BITS-1:0]          next_wdata_i,
  input  wire logic [IdxBits-1:0]           value_raddr_i,
  output logic signed [VALUE_BITS-1:0]      value_rdata_o,
  input  wire logic [IdxBits-1:0]           value_waddr_i,
  input  wire logic signed [VALUE_BITS-1:0] value_wdata_i
);

  logic [PTR_BITS-1:0]   next_mem  [NODES];
  logic [VALUE_BITS-1:0] value_mem [NODES];

  always_ff @(posedge clk_i) begin
    if (wr_i.next_we) begin
      next_mem[next_waddr_i] <= next_wdata_i;
    end
    next_rdata_o <= next_mem[next_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.value_we) begin
      value_mem[value_waddr_i] <= value_wdata_i;
    end
    value_rdata_o <= value_mem[value_raddr_i];
  end

endmodule

`default_nettype wire

// ----- hdl/singly_linked_list_cursor.sv -----
// Top level of the linked list with cursor: pointer registers, the operation
// sequencer and the result registers. Depends on sllc_pkg and sllc_node_mem.
//
//   Port group   Dir  Handshake            Contents
//   command      in   start_i / busy_o     op_i, value_in_i
//   result       out  done_o (one cycle)   value_out_o, status_o, cursor_active_o
//
// Steps per item: clear, cursor to head, write at cursor, insert at head from unused
// nodes and every operation that finds nothing to do at its first step end in S_IDLE;
// reads, delete head, advance, insert at head from the free list and delete after on
// the last node end in S_A; insert after from unused nodes goes to S_B and S_C; delete
// after and insert after from the free list pass S_A, S_B and S_C. The single read and
// write port of the link memory sets these.
// The result strobe rises the cycle after the last step; a new item may start then.
// Reset empties the list at once: no pass over the node memory is made.
`default_nettype none

module singly_linked_list_cursor
  import sllc_pkg::*;
#(
  parameter int POOL_NODES = 256,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [3:0]                   op_i,
  input  wire logic signed [VALUE_BITS-1:0] value_in_i,
  output logic                              done_o,
  output logic signed [VALUE_BITS-1:0]      value_out_o,
  output logic [1:0]                        status_o,
  output logic                              cursor_active_o
);

  localparam int IdxBits = $clog2(POOL_NODES);
  localparam int PtrBits = $clog2(POOL_NODES + 1);
  localparam logic [PtrBits-1:0] Nil = PtrBits'(POOL_NODES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_A    = 2'd1;
  localparam logic [1:0] S_B    = 2'd2;
  localparam logic [1:0] S_C    = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [PtrBits-1:0]           head_q, head_d;
  logic [PtrBits-1:0]           cursor_q, cursor_d;
  logic [PtrBits-1:0]           free_q, free_d;
  logic [PtrBits-1:0]           fresh_q, fresh_d;
  logic [PtrBits-1:0]           node_q, node_d;
  logic                         done_q, done_d;
  op_e                          op_q, op_d;
  logic signed [VALUE_BITS-1:0] val_q, val_d;
  logic signed [VALUE_BITS-1:0] value_q, value_d;
  logic [1:0]                   status_q, status_d;

  mem_wr_t                      mem_wr;
  logic [IdxBits-1:0]           next_raddr, next_waddr, value_raddr, value_waddr;
  logic [PtrBits-1:0]           next_rdata, next_wdata;
  logic signed [VALUE_BITS-1:0] value_rdata, value_wdata;
  logic                         accept;

  function automatic logic is_node(input logic [PtrBits-1:0] p);
    return p < Nil;
  endfunction

  function automatic logic [IdxBits-1:0] idx(input logic [PtrBits-1:0] p);
    return p[IdxBits-1:0];
  endfunction

  assign busy_o          = (state_q != S_IDLE);
  assign accept          = start_i && !busy_o;
  assign done_o          = done_q;
  assign value_out_o     = value_q;
  assign status_o        = status_q;
  assign cursor_active_o = is_node(cursor_q);

  always_comb begin
    logic                         fin;
    logic [1:0]                   stat;
    logic signed [VALUE_BITS-1:0] rdv;
    fin         = 1'b0;
    stat        = STAT_OK;
    rdv         = '0;
    state_d     = state_q;
    head_d      = head_q;
    cursor_d    = cursor_q;
    free_d      = free_q;
    fresh_d     = fresh_q;
    node_d      = node_q;
    op_d        = op_q;
    val_d       = val_q;
    mem_wr      = '0;
    next_raddr  = '0;
    next_waddr  = '0;
    next_wdata  = '0;
    value_raddr = '0;
    value_waddr = '0;
    value_wdata = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d  = op_e'(op_i);
          val_d = value_in_i;
          unique case (op_e'(op_i))
            OP_CLEAR: begin
              head_d   = Nil;
              cursor_d = Nil;
              free_d   = Nil;
              fresh_d  = '0;
              fin      = 1'b1;
            end
            OP_INS_HEAD: begin
              if (is_node(free_q)) begin
                next_raddr = idx(free_q);
                state_d    = S_A;
              end else if (fresh_q < Nil) begin
                mem_wr.next_we  = 1'b1;
                mem_wr.value_we = 1'b1;
                next_waddr      = idx(fresh_q);
                next_wdata      = head_q;
                value_waddr     = idx(fresh_q);
                value_wdata     = value_in_i;
                head_d          = fresh_q;
                fresh_d         = fresh_q + PtrBits'(1);
                fin             = 1'b1;
              end else begin
                stat = STAT_FULL;
                fin  = 1'b1;
              end
            end
            OP_CUR_TO_HEAD: begin
              cursor_d = head_q;
              fin      = 1'b1;
            end
            OP_READ_HEAD: begin
              if (is_node(head_q)) begin
                value_raddr = idx(head_q);
                state_d     = S_A;
              end else begin
                stat = STAT_EMPTY;
                fin  = 1'b1;
              end
            end
            OP_DEL_HEAD: begin
              if (is_node(head_q)) begin
                next_raddr = idx(head_q);
                state_d    = S_A;
              end else begin
                fin = 1'b1;
              end
            end
            OP_DEL_AFTER, OP_ADVANCE: begin
              if (is_node(cursor_q)) begin
                next_raddr = idx(cursor_q);
                state_d    = S_A;
              end else begin
                fin = 1'b1;
              end
            end
            OP_INS_AFTER: begin
              if (!is_node(cursor_q)) begin
                fin = 1'b1;
              end else if (is_node(free_q)) begin
                next_raddr = idx(free_q);
                state_d    = S_A;
              end else if (fresh_q < Nil) begin
                node_d     = fresh_q;
                fresh_d    = fresh_q + PtrBits'(1);
                next_raddr = idx(cursor_q);
                state_d    = S_B;
              end else begin
                stat = STAT_FULL;
                fin  = 1'b1;
              end
            end
            OP_READ_CUR: begin
              if (is_node(cursor_q)) begin
                value_raddr = idx(cursor_q);
                state_d     = S_A;
              end else begin
                stat = STAT_NO_CURSOR;
                fin  = 1'b1;
              end
            end
            OP_WRITE_CUR: begin
              if (is_node(cursor_q)) begin
                mem_wr.value_we = 1'b1;
                value_waddr     = idx(cursor_q);
                value_wdata     = value_in_i;
              end
              fin = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_A: begin
        unique case (op_q)
          OP_INS_HEAD: begin
            mem_wr.next_we  = 1'b1;
            mem_wr.value_we = 1'b1;
            next_waddr      = idx(free_q);
            next_wdata      = head_q;
            value_waddr     = idx(free_q);
            value_wdata     = val_q;
            head_d          = free_q;
            free_d          = next_rdata;
            fin             = 1'b1;
          end
          OP_READ_HEAD, OP_READ_CUR: begin
            rdv = value_rdata;
            fin = 1'b1;
          end
          OP_DEL_HEAD: begin
            mem_wr.next_we = 1'b1;
            next_waddr     = idx(head_q);
            next_wdata     = free_q;
            free_d         = head_q;
            head_d         = next_rdata;
            if (cursor_q == head_q) begin
              cursor_d = Nil;
            end
            fin = 1'b1;
          end
          OP_DEL_AFTER: begin
            if (is_node(next_rdata)) begin
              node_d     = next_rdata;
              next_raddr = idx(next_rdata);
              state_d    = S_B;
            end else begin
              fin = 1'b1;
            end
          end
          OP_INS_AFTER: begin
            node_d     = free_q;
            free_d     = next_rdata;
            next_raddr = idx(cursor_q);
            state_d    = S_B;
          end
          OP_ADVANCE: begin
            cursor_d = next_rdata;
            fin      = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      S_B: begin
        unique case (op_q)
          OP_DEL_AFTER: begin
            mem_wr.next_we = 1'b1;
            next_waddr     = idx(cursor_q);
            next_wdata     = next_rdata;
            state_d        = S_C;
          end
          OP_INS_AFTER: begin
            mem_wr.next_we  = 1'b1;
            mem_wr.value_we = 1'b1;
            next_waddr      = idx(node_q);
            next_wdata      = next_rdata;
            value_waddr     = idx(node_q);
            value_wdata     = val_q;
            state_d         = S_C;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      S_C: begin
        unique case (op_q)
          OP_DEL_AFTER: begin
            mem_wr.next_we = 1'b1;
            next_waddr     = idx(node_q);
            next_wdata     = free_q;
            free_d         = node_q;
          end
          OP_INS_AFTER: begin
            mem_wr.next_we = 1'b1;
            next_waddr     = idx(cursor_q);
            next_wdata     = node_q;
          end
          default: begin
          end
        endcase
        fin = 1'b1;
      end

      default: begin
        fin = 1'b1;
      end
    endcase

    done_d   = fin;
    status_d = fin ? stat : status_q;
    value_d  = fin ? rdv : value_q;
    if (fin) begin
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= Nil;
      cursor_q <= Nil;
      free_q   <= Nil;
      fresh_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      cursor_q <= cursor_d;
      free_q   <= free_d;
      fresh_q  <= fresh_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    val_q    <= val_d;
    node_q   <= node_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  sllc_node_mem #(
    .NODES      (POOL_NODES),
    .PTR_BITS   (PtrBits),
    .VALUE_BITS (VALUE_BITS)
  ) u_node_mem (
    .clk_i         (clk_i),
    .wr_i          (mem_wr),
    .next_raddr_i  (next_raddr),
    .next_rdata_o  (next_rdata),
    .next_waddr_i  (next_waddr),
    .next_wdata_i  (next_wdata),
    .value_raddr_i (value_raddr),
    .value_rdata_o (value_rdata),
    .value_waddr_i (value_waddr),
    .value_wdata_i (value_wdata)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_o)
    else $error("Result strobe while an item is still in progress.");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (done_q || busy_o))
    else $error("Accepted item neither finished nor in progress.");

  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_C |=> done_q)
    else $error("Final link write did not produce a result.");

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= Nil)
    else $error("Unused-node counter ran past the pool size.");

  a_full_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == STAT_FULL) |-> (op_q == OP_INS_HEAD || op_q == OP_INS_AFTER))
    else $error("Pool-full status reported for an operation that allocates nothing.");

endmodule

`default_nettype wire
